/* hdl/mvn_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvn_pkg
// Shared types and constants for the mesh vertex normal engine.
// ----------------------------------------------------------------------------
package mvn_pkg;

    localparam int IDX_W = 12;
    localparam int NRM_W = 16;
    localparam int OP_W  = 2;
    localparam int MUL_W = 31;
    localparam int SUM_W = 62;
    localparam int CNT_W = 5;

    localparam int MAX_VERTICES_DEF     = 4096;
    localparam int COORD_BITS_DEF       = 20;
    localparam int NORMAL_FRAC_BITS_DEF = 14;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_FACE  = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [12:0] {
        ST_IDLE = 13'b0000000000001,
        ST_CLR  = 13'b0000000000010,
        ST_RDV  = 13'b0000000000100,
        ST_DIF  = 13'b0000000001000,
        ST_MUL  = 13'b0000000010000,
        ST_MAG  = 13'b0000000100000,
        ST_NRM  = 13'b0000001000000,
        ST_SQR  = 13'b0000010000000,
        ST_ROOT = 13'b0000100000000,
        ST_DIV  = 13'b0001000000000,
        ST_WR   = 13'b0010000000000,
        ST_RDN  = 13'b0100000000000,
        ST_OUT  = 13'b1000000000000
    } t_state;

endpackage

/* hdl/mesh_vertex_normal_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_vertex_normal_engine
// Vertex store, per-vertex normal store and a sequenced face normal datapath.
// ----------------------------------------------------------------------------
// vertex write taken at once; normal read registered via ST_RDN and ST_OUT; clear walks all entries
// face: sequenced through the shared 31x31 multiplier, a one-bit-per-step normalize, the
//   bit-serial square root (31 steps) and the restoring divider (once per component);
//   a degenerate face skips from the magnitude step straight to the normal write
// throughput: one transaction at a time; o_in_stall is high while busy
// reset: sync active low; a pass over all MAX_VERTICES entries then clears the normal store
module mesh_vertex_normal_engine
    import mvn_pkg::*;
#(
    parameter int MAX_VERTICES     = MAX_VERTICES_DEF,
    parameter int COORD_BITS       = COORD_BITS_DEF,
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [OP_W-1:0]              i_operation,
    input  logic [IDX_W-1:0]             i_index_a,
    input  logic [IDX_W-1:0]             i_index_b,
    input  logic [IDX_W-1:0]             i_index_c,
    input  logic signed [COORD_BITS-1:0] i_coord_x,
    input  logic signed [COORD_BITS-1:0] i_coord_y,
    input  logic signed [COORD_BITS-1:0] i_coord_z,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_result_kind,
    output logic signed [NRM_W-1:0]      o_normal_x,
    output logic signed [NRM_W-1:0]      o_normal_y,
    output logic signed [NRM_W-1:0]      o_normal_z,
    output logic                         o_is_zero
);

    localparam int AW  = $clog2(MAX_VERTICES);
    localparam int SH  = (COORD_BITS > 30) ? COORD_BITS - 30 : 0;
    localparam int DW  = ((COORD_BITS > 30) ? 30 : COORD_BITS) + 1;
    localparam int CW  = 2 * DW + 1;
    localparam int MW  = (CW > 31) ? CW : 31;
    localparam int NW  = 31 + NORMAL_FRAC_BITS;
    localparam int QW  = NORMAL_FRAC_BITS + 1;
    localparam int VW  = 3 * COORD_BITS;
    localparam int NMW = 3 * NRM_W + 1;

    function automatic logic signed [DW-1:0] f_diff(input logic signed [COORD_BITS-1:0] p,
                                                    input logic signed [COORD_BITS-1:0] q);
        logic signed [COORD_BITS:0] d;
        logic [COORD_BITS:0]        m;
        logic [COORD_BITS:0]        ms;
        logic signed [DW-1:0]       r;
        d  = {p[COORD_BITS-1], p} - {q[COORD_BITS-1], q};
        m  = d[COORD_BITS] ? (~d + 1'b1) : d;
        ms = m >> SH;
        r  = DW'(ms);
        f_diff = d[COORD_BITS] ? -r : r;
    endfunction

    function automatic logic f_idx_ok(input logic [IDX_W-1:0] idx);
        f_idx_ok = (32'(idx) < 32'(MAX_VERTICES));
    endfunction

    // storage
    logic [VW-1:0]  vmem [MAX_VERTICES];
    logic [NMW-1:0] nmem [MAX_VERTICES];
    logic [VW-1:0]  r_vrd;
    logic [NMW-1:0] r_nrd;

    t_state r_state;
    logic [CNT_W-1:0] r_cnt;
    logic [AW-1:0]    r_clr_addr;
    logic [1:0]       r_ci;

    logic [IDX_W-1:0] r_ia, r_ib, r_ic;
    logic             r_a_ok;
    logic             r_kind;
    logic             r_zero;

    logic signed [COORD_BITS-1:0] r_va [3];
    logic signed [COORD_BITS-1:0] r_vb [3];
    logic signed [COORD_BITS-1:0] r_vc [3];
    logic signed [DW-1:0]         r_u [3];
    logic signed [DW-1:0]         r_v [3];
    logic signed [CW-1:0]         r_cr [3];
    logic [MW-1:0]                r_m [3];
    logic signed [2*MUL_W-1:0]    r_prod;
    logic [SUM_W-1:0]             r_s;
    logic [SUM_W-1:0]             r_res;
    logic [SUM_W-1:0]             r_bit;
    logic [NW-1:0]                r_rem;
    logic [NW-1:0]                r_d;
    logic [QW-1:0]                r_q;
    logic signed [NRM_W-1:0]      r_n [3];

    logic                    r_ov;
    logic                    r_okind;
    logic signed [NRM_W-1:0] r_onx, r_ony, r_onz;
    logic                    r_ozero;

    logic in_acc, out_acc, out_free;
    t_op  op_in;
    logic in_ok;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_acc  = r_ov && !i_out_stall;
    assign out_free = !r_ov || !i_out_stall;
    assign op_in    = t_op'(i_operation);
    assign in_ok    = f_idx_ok(i_index_a) && f_idx_ok(i_index_b) && f_idx_ok(i_index_c);
    assign o_in_stall = (r_state != ST_IDLE);

    // vertex memory
    logic [AW-1:0] vaddr;
    always_comb begin
        case (r_cnt)
            CNT_W'(0): vaddr = AW'(r_ia);
            CNT_W'(1): vaddr = AW'(r_ib);
            default:   vaddr = AW'(r_ic);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && op_in == OP_WRITE && f_idx_ok(i_index_a)) begin
            vmem[AW'(i_index_a)] <= {i_coord_x, i_coord_y, i_coord_z};
        end
        r_vrd <= vmem[vaddr];
    end

    // normal memory: {valid, x, y, z}
    logic           nm_we;
    logic [AW-1:0]  nm_wa;
    logic [NMW-1:0] nm_wd;
    always_comb begin
        nm_we = 1'b0;
        nm_wa = r_clr_addr;
        nm_wd = '0;
        if (r_state == ST_CLR) begin
            nm_we = 1'b1;
        end else if (r_state == ST_WR) begin
            nm_we = 1'b1;
            nm_wa = vaddr;
            nm_wd = {1'b1, r_n[0], r_n[1], r_n[2]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (nm_we) begin
            nm_wd_write: nmem[nm_wa] <= nm_wd;
        end
        r_nrd <= nmem[AW'(r_ia)];
    end

    // shared multiplier operands
    logic signed [MUL_W-1:0] mul_a, mul_b;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == ST_MUL) begin
            case (r_cnt)
                CNT_W'(0): begin mul_a = MUL_W'(r_u[1]); mul_b = MUL_W'(r_v[2]); end
                CNT_W'(1): begin mul_a = MUL_W'(r_u[2]); mul_b = MUL_W'(r_v[1]); end
                CNT_W'(2): begin mul_a = MUL_W'(r_u[2]); mul_b = MUL_W'(r_v[0]); end
                CNT_W'(3): begin mul_a = MUL_W'(r_u[0]); mul_b = MUL_W'(r_v[2]); end
                CNT_W'(4): begin mul_a = MUL_W'(r_u[0]); mul_b = MUL_W'(r_v[1]); end
                CNT_W'(5): begin mul_a = MUL_W'(r_u[1]); mul_b = MUL_W'(r_v[0]); end
                default: begin end
            endcase
        end else begin
            case (r_cnt)
                CNT_W'(0): mul_a = signed'({1'b0, r_m[0][29:0]});
                CNT_W'(1): mul_a = signed'({1'b0, r_m[1][29:0]});
                CNT_W'(2): mul_a = signed'({1'b0, r_m[2][29:0]});
                default:   mul_a = '0;
            endcase
            mul_b = mul_a;
        end
    end

    // magnitude, normalize, root and divide helpers
    logic [CW-1:0]    mag_sel;
    logic [MW-1:0]    or_m;
    logic [SUM_W-1:0] root_t;
    logic [30:0]      len;
    logic             div_ge;
    logic [QW-1:0]    q_nx;
    logic [NRM_W-1:0] q_cl;
    logic             cr_sign;
    logic             cr_zero;

    always_comb begin
        case (r_cnt)
            CNT_W'(0): mag_sel = r_cr[0][CW-1] ? CW'(-r_cr[0]) : CW'(r_cr[0]);
            CNT_W'(1): mag_sel = r_cr[1][CW-1] ? CW'(-r_cr[1]) : CW'(r_cr[1]);
            default:   mag_sel = r_cr[2][CW-1] ? CW'(-r_cr[2]) : CW'(r_cr[2]);
        endcase
        case (r_ci)
            2'd0:    cr_sign = r_cr[0][CW-1];
            2'd1:    cr_sign = r_cr[1][CW-1];
            default: cr_sign = r_cr[2][CW-1];
        endcase
        or_m    = r_m[0] | r_m[1] | r_m[2];
        root_t  = r_res + r_bit;
        len     = r_res[30:0];
        div_ge  = (r_rem >= r_d);
        q_nx    = {r_q[QW-2:0], div_ge};
        q_cl    = (32'(q_nx) > 32'd32767) ? NRM_W'(32767) : NRM_W'(q_nx);
        cr_zero = (r_cr[0] == '0) && (r_cr[1] == '0) && (r_cr[2] == '0);
    end

    logic [MW-1:0] m_div;
    always_comb begin
        case (r_ci)
            2'd0:    m_div = r_m[0];
            2'd1:    m_div = r_m[1];
            default: m_div = r_m[2];
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLR;
            r_cnt      <= '0;
            r_clr_addr <= '0;
            r_ci       <= '0;
            r_ov       <= 1'b0;
        end else begin
            // a new result loaded in ST_OUT takes the slot instead
            if (out_acc && r_state != ST_OUT) begin
                r_ov <= 1'b0;
            end
            r_prod <= mul_a * mul_b;
            case (r_state)
                ST_IDLE: begin
                    r_cnt <= '0;
                    r_ci  <= '0;
                    if (in_acc) begin
                        r_ia   <= i_index_a;
                        r_ib   <= i_index_b;
                        r_ic   <= i_index_c;
                        r_a_ok <= f_idx_ok(i_index_a);
                        case (op_in)
                            OP_FACE: begin
                                r_kind <= 1'b0;
                                if (in_ok) begin
                                    r_state <= ST_RDV;
                                end else begin
                                    r_zero  <= 1'b1;
                                    r_n[0]  <= '0;
                                    r_n[1]  <= '0;
                                    r_n[2]  <= '0;
                                    r_state <= ST_OUT;
                                end
                            end
                            OP_READ: begin
                                r_kind  <= 1'b1;
                                r_state <= ST_RDN;
                            end
                            OP_CLEAR: begin
                                r_clr_addr <= '0;
                                r_state    <= ST_CLR;
                            end
                            default: begin end
                        endcase
                    end
                end
                ST_CLR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(MAX_VERTICES - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_RDV: begin
                    r_cnt <= r_cnt + 1'b1;
                    case (r_cnt)
                        CNT_W'(1): begin
                            r_va[0] <= r_vrd[VW-1 -: COORD_BITS];
                            r_va[1] <= r_vrd[2*COORD_BITS-1 -: COORD_BITS];
                            r_va[2] <= r_vrd[COORD_BITS-1:0];
                        end
                        CNT_W'(2): begin
                            r_vb[0] <= r_vrd[VW-1 -: COORD_BITS];
                            r_vb[1] <= r_vrd[2*COORD_BITS-1 -: COORD_BITS];
                            r_vb[2] <= r_vrd[COORD_BITS-1:0];
                        end
                        CNT_W'(3): begin
                            r_vc[0] <= r_vrd[VW-1 -: COORD_BITS];
                            r_vc[1] <= r_vrd[2*COORD_BITS-1 -: COORD_BITS];
                            r_vc[2] <= r_vrd[COORD_BITS-1:0];
                            r_cnt   <= '0;
                            r_state <= ST_DIF;
                        end
                        default: begin end
                    endcase
                end
                ST_DIF: begin
                    r_cnt <= r_cnt + 1'b1;
                    case (r_cnt)
                        CNT_W'(0): r_u[0] <= f_diff(r_va[0], r_vb[0]);
                        CNT_W'(1): r_u[1] <= f_diff(r_va[1], r_vb[1]);
                        CNT_W'(2): r_u[2] <= f_diff(r_va[2], r_vb[2]);
                        CNT_W'(3): r_v[0] <= f_diff(r_vc[0], r_vb[0]);
                        CNT_W'(4): r_v[1] <= f_diff(r_vc[1], r_vb[1]);
                        default: begin
                            r_v[2]  <= f_diff(r_vc[2], r_vb[2]);
                            r_cnt   <= '0;
                            r_state <= ST_MUL;
                        end
                    endcase
                end
                ST_MUL: begin
                    // product registered, then accumulated in the cycle after
                    r_cnt <= r_cnt + 1'b1;
                    case (r_cnt)
                        CNT_W'(1): r_cr[0] <= CW'(r_prod);
                        CNT_W'(2): r_cr[0] <= r_cr[0] - CW'(r_prod);
                        CNT_W'(3): r_cr[1] <= CW'(r_prod);
                        CNT_W'(4): r_cr[1] <= r_cr[1] - CW'(r_prod);
                        CNT_W'(5): r_cr[2] <= CW'(r_prod);
                        CNT_W'(6): begin
                            r_cr[2] <= r_cr[2] - CW'(r_prod);
                            r_cnt   <= '0;
                            r_state <= ST_MAG;
                        end
                        default: begin end
                    endcase
                end
                ST_MAG: begin
                    r_cnt <= r_cnt + 1'b1;
                    case (r_cnt)
                        CNT_W'(0): r_m[0] <= MW'(mag_sel);
                        CNT_W'(1): r_m[1] <= MW'(mag_sel);
                        default: begin
                            r_m[2] <= MW'(mag_sel);
                            r_cnt  <= '0;
                            if (cr_zero) begin
                                r_zero  <= 1'b1;
                                r_n[0]  <= '0;
                                r_n[1]  <= '0;
                                r_n[2]  <= '0;
                                r_state <= ST_WR;
                            end else begin
                                r_zero  <= 1'b0;
                                r_state <= ST_NRM;
                            end
                        end
                    endcase
                end
                ST_NRM: begin
                    // one bit a cycle until the largest magnitude sits in [2^29, 2^30)
                    if (|or_m[MW-1:30]) begin
                        r_m[0] <= r_m[0] >> 1;
                        r_m[1] <= r_m[1] >> 1;
                        r_m[2] <= r_m[2] >> 1;
                    end else if (!or_m[29]) begin
                        r_m[0] <= r_m[0] << 1;
                        r_m[1] <= r_m[1] << 1;
                        r_m[2] <= r_m[2] << 1;
                    end else begin
                        r_cnt   <= '0;
                        r_state <= ST_SQR;
                    end
                end
                ST_SQR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        r_s <= SUM_W'(unsigned'(r_prod));
                    end else if (r_cnt != CNT_W'(0)) begin
                        r_s <= r_s + SUM_W'(unsigned'(r_prod));
                    end
                    if (r_cnt == CNT_W'(3)) begin
                        r_res   <= '0;
                        r_bit   <= SUM_W'(1) << (SUM_W - 2);
                        r_cnt   <= '0;
                        r_state <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_s >= root_t) begin
                        r_s   <= r_s - root_t;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_cnt == CNT_W'(SUM_W / 2 - 1)) begin
                        r_cnt   <= '0;
                        r_ci    <= '0;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(0)) begin
                        r_rem <= (NW'(m_div[29:0]) << NORMAL_FRAC_BITS) + NW'(len >> 1);
                        r_d   <= NW'(len) << NORMAL_FRAC_BITS;
                        r_q   <= '0;
                    end else begin
                        if (div_ge) begin
                            r_rem <= r_rem - r_d;
                        end
                        r_d <= r_d >> 1;
                        r_q <= q_nx;
                        if (r_cnt == CNT_W'(QW)) begin
                            r_n[r_ci] <= cr_sign ? -signed'(q_cl) : signed'(q_cl);
                            r_cnt     <= '0;
                            if (r_ci == 2'd2) begin
                                r_state <= ST_WR;
                            end else begin
                                r_ci <= r_ci + 1'b1;
                            end
                        end
                    end
                end
                ST_WR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(2)) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_RDN: begin
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_ov    <= 1'b1;
                        r_okind <= r_kind;
                        if (!r_kind) begin
                            r_onx   <= r_n[0];
                            r_ony   <= r_n[1];
                            r_onz   <= r_n[2];
                            r_ozero <= r_zero;
                        end else if (r_a_ok && r_nrd[NMW-1]) begin
                            r_onx   <= r_nrd[3*NRM_W-1 -: NRM_W];
                            r_ony   <= r_nrd[2*NRM_W-1 -: NRM_W];
                            r_onz   <= r_nrd[NRM_W-1:0];
                            r_ozero <= (r_nrd[3*NRM_W-1:0] == '0);
                        end else begin
                            r_onx   <= '0;
                            r_ony   <= '0;
                            r_onz   <= '0;
                            r_ozero <= 1'b1;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid   = r_ov;
    assign o_result_kind = r_okind;
    assign o_normal_x    = r_onx;
    assign o_normal_y    = r_ony;
    assign o_normal_z    = r_onz;
    assign o_is_zero     = r_ozero;

`ifndef NO_ASSERTIONS
    // a result flagged nonzero carries a nonzero vector
    a_nonzero_vec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_ozero) |-> (r_onx != '0 || r_ony != '0 || r_onz != '0))
        else $error("nonzero result with zero vector");

    // any face, read or clear transaction makes the block busy next cycle
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && op_in != OP_WRITE) |=> o_in_stall)
        else $error("block not busy after transaction");

    // normalization leaves the largest magnitude in [2^29, 2^30)
    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQR && r_cnt == '0) |-> (or_m[29] && !(|or_m[MW-1:30])))
        else $error("normalization out of range");

    // square root of a normalized sum lies in [2^29, 2^31)
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_res[30:29] != 2'b00 && r_res[SUM_W-1:31] == '0))
        else $error("length out of range");
`endif

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for mesh_vertex_normal_engine: a directed opening, then
// random vertex writes, faces, reads and clears. Every result is predicted by
// a fixed-point face normal model and checked in order. Both handshakes idle
// at random.
// ----------------------------------------------------------------------------
module tb_top;
    import mvn_pkg::*;

    localparam int NVERT     = MAX_VERTICES_DEF;
    localparam int FRAC      = NORMAL_FRAC_BITS_DEF;
    localparam int IDLE_LIMIT = 30000;

    class normal_scoreboard;
        longint              coords [NVERT][3];
        logic signed [15:0]  normals [NVERT][3];
        bit                  has_normal [NVERT];
        logic [50:0]         pending_results [$];
        int                  fails;

        function longint unsigned isqrt(longint unsigned s);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > s) b = b >> 2;
            while (b != 0) begin
                if (s >= res + b) begin
                    s = s - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        // returns 1 for a degenerate face
        function bit face_normal(int a, int b, int c, output logic signed [15:0] n [3]);
            longint u [3], v [3], cr [3];
            longint unsigned m [3], mx, s, len, q;
            int bl;
            for (int i = 0; i < 3; i++) begin
                u[i] = coords[a][i] - coords[b][i];
                v[i] = coords[c][i] - coords[b][i];
            end
            cr[0] = u[1] * v[2] - u[2] * v[1];
            cr[1] = u[2] * v[0] - u[0] * v[2];
            cr[2] = u[0] * v[1] - u[1] * v[0];
            for (int i = 0; i < 3; i++) m[i] = cr[i] < 0 ? -cr[i] : cr[i];
            mx = m[0];
            if (m[1] > mx) mx = m[1];
            if (m[2] > mx) mx = m[2];
            for (int i = 0; i < 3; i++) n[i] = '0;
            if (mx == 0) return 1;
            bl = 0;
            while (bl < 64 && (mx >> bl) != 0) bl++;
            for (int i = 0; i < 3; i++)
                m[i] = (bl > 30) ? (m[i] >> (bl - 30)) : (m[i] << (30 - bl));
            s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
            len = isqrt(s);
            for (int i = 0; i < 3; i++) begin
                q = ((m[i] << FRAC) + (len >> 1)) / len;
                if (q > 32767) q = 32767;
                n[i] = cr[i] < 0 ? -16'(q) : 16'(q);
            end
            return 0;
        endfunction

        function void reset_state();
            for (int i = 0; i < NVERT; i++) has_normal[i] = 0;
            fails = 0;
        endfunction

        function void note_input(t_op op, int a, int b, int c, logic signed [19:0] x,
                                 logic signed [19:0] y, logic signed [19:0] z);
            logic signed [15:0] n [3];
            bit zero;
            case (op)
                OP_WRITE: begin
                    coords[a][0] = longint'(x);
                    coords[a][1] = longint'(y);
                    coords[a][2] = longint'(z);
                end
                OP_CLEAR: begin
                    for (int i = 0; i < NVERT; i++) has_normal[i] = 0;
                end
                OP_READ: begin
                    zero = 1;
                    for (int i = 0; i < 3; i++) n[i] = '0;
                    if (has_normal[a]) begin
                        for (int i = 0; i < 3; i++) n[i] = normals[a][i];
                        zero = (n[0] == 0 && n[1] == 0 && n[2] == 0);
                    end
                    pending_results.push_back({1'b1, n[0], n[1], n[2], zero, 1'b0});
                end
                OP_FACE: begin
                    zero = face_normal(a, b, c, n);
                    for (int i = 0; i < 3; i++) begin
                        normals[a][i] = n[i];
                        normals[b][i] = n[i];
                        normals[c][i] = n[i];
                    end
                    has_normal[a] = 1;
                    has_normal[b] = 1;
                    has_normal[c] = 1;
                    pending_results.push_back({1'b0, n[0], n[1], n[2], zero, 1'b0});
                end
                default: begin end
            endcase
        endfunction

        function void check_result(logic kind, logic signed [15:0] nx,
                                   logic signed [15:0] ny, logic signed [15:0] nz,
                                   logic zero);
            logic [50:0] e;
            if (pending_results.size() == 0) begin
                $error("result with no transaction outstanding");
                fails++;
                return;
            end
            e = pending_results.pop_front();
            if (kind !== e[50]) begin
                $error("result_kind expected %0d actual %0d", e[50], kind);
                fails++;
            end
            if (nx !== e[49:34]) begin
                $error("normal_x expected %0d actual %0d", $signed(e[49:34]), nx);
                fails++;
            end
            if (ny !== e[33:18]) begin
                $error("normal_y expected %0d actual %0d", $signed(e[33:18]), ny);
                fails++;
            end
            if (nz !== e[17:2]) begin
                $error("normal_z expected %0d actual %0d", $signed(e[17:2]), nz);
                fails++;
            end
            if (zero !== e[1]) begin
                $error("is_zero expected %0d actual %0d", e[1], zero);
                fails++;
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic                   i_clk = 0;
    logic                   i_rst_n = 0;
    logic                   i_in_valid = 0;
    logic                   o_in_stall;
    logic [OP_W-1:0]        i_operation = '0;
    logic [IDX_W-1:0]       i_index_a = '0;
    logic [IDX_W-1:0]       i_index_b = '0;
    logic [IDX_W-1:0]       i_index_c = '0;
    logic signed [19:0]     i_coord_x = '0;
    logic signed [19:0]     i_coord_y = '0;
    logic signed [19:0]     i_coord_z = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 0;
    logic                   o_result_kind;
    logic signed [15:0]     o_normal_x;
    logic signed [15:0]     o_normal_y;
    logic signed [15:0]     o_normal_z;
    logic                   o_is_zero;

    normal_scoreboard sb;
    bit  burst_mode;
    int  idle_cycles = 0;
    int  written [$];
    bit  is_written [NVERT];

    mesh_vertex_normal_engine dut (.*);

    always #2 i_clk = ~i_clk;

    task automatic send(t_op op, int a, int b, int c, logic signed [19:0] x,
                        logic signed [19:0] y, logic signed [19:0] z);
        int gap;
        bit ok;
        gap = burst_mode ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1;
        i_operation <= op;
        i_index_a   <= IDX_W'(a);
        i_index_b   <= IDX_W'(b);
        i_index_c   <= IDX_W'(c);
        i_coord_x   <= x;
        i_coord_y   <= y;
        i_coord_z   <= z;
        do begin
            @(negedge i_clk);
            ok = !o_in_stall;
            @(posedge i_clk);
        end while (!ok);
        sb.note_input(op, a, b, c, x, y, z);
        if (op == OP_WRITE && !is_written[a]) begin
            is_written[a] = 1;
            written.push_back(a);
        end
    endtask

    function automatic logic signed [19:0] rand_coord();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom_range(0, 1) ? 20'sh7ffff : 20'sh80000;
            2, 3, 4: return $signed(20'($urandom_range(0, 127))) - 20'sd64;
            default: return 20'($urandom);
        endcase
    endfunction

    function automatic int pick_written();
        return written[$urandom_range(0, written.size() - 1)];
    endfunction

    task automatic wait_drained();
        i_in_valid <= 0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // result side: random stall per transaction, one long hold-off
    initial begin
        int  w, taken;
        bit  got;
        taken = 0;
        @(posedge i_rst_n);
        forever begin
            w = (taken == 300) ? 500 : (burst_mode ? 0 : $urandom_range(0, 16));
            if (w > 0) begin
                i_out_stall <= 1;
                repeat (w) @(posedge i_clk);
            end
            i_out_stall <= 0;
            do begin
                @(negedge i_clk);
                got = o_out_valid;
                if (got)
                    sb.check_result(o_result_kind, o_normal_x, o_normal_y, o_normal_z,
                                    o_is_zero);
                @(posedge i_clk);
            end while (!got);
            taken++;
        end
    end

    // watchdog on cycles without any transaction
    always @(negedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int r, a, b, c;
        sb = new();
        sb.reset_state();
        burst_mode = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;

        // directed opening
        send(OP_READ,  7, 0, 0, 0, 0, 0);
        send(OP_WRITE, 0, 0, 0, 20'sh7ffff, 20'sh7ffff, 20'sh7ffff);
        send(OP_WRITE, 1, 0, 0, 20'sh80000, 20'sh80000, 20'sh80000);
        send(OP_WRITE, 2, 0, 0, 0, 0, 0);
        send(OP_WRITE, 3, 0, 0, 20'sd1, 0, 0);
        send(OP_WRITE, 4, 0, 0, 0, 20'sd1, 0);
        send(OP_WRITE, 4095, 4095, 4095, 20'sh80000, 20'sh7ffff, 20'sh80000);
        send(OP_WRITE, 5, 0, 0, 20'sh7ffff, 20'sh80000, 0);
        send(OP_FACE,  3, 2, 4, 0, 0, 0);
        send(OP_FACE,  0, 1, 2, 0, 0, 0);      // collinear corners
        send(OP_FACE,  3, 3, 4, 0, 0, 0);      // repeated corner
        send(OP_READ,  3, 0, 0, 0, 0, 0);
        send(OP_READ,  0, 0, 0, 0, 0, 0);
        send(OP_READ,  4095, 0, 0, 0, 0, 0);
        send(OP_FACE,  4095, 5, 0, 0, 0, 0);
        send(OP_FACE,  1, 4095, 5, 0, 0, 0);
        send(OP_READ,  4095, 0, 0, 0, 0, 0);
        send(OP_CLEAR, 0, 0, 0, 0, 0, 0);
        send(OP_READ,  4095, 0, 0, 0, 0, 0);
        send(OP_READ,  3, 0, 0, 0, 0, 0);
        send(OP_FACE,  4, 2, 3, 0, 0, 0);
        send(OP_READ,  2, 0, 0, 0, 0, 0);

        for (int n = 0; n < 1700; n++) begin
            if (n % 100 == 0) burst_mode = ($urandom_range(0, 3) == 0);
            if (n == 800) wait_drained();
            r = $urandom_range(0, 99);
            if (r < 40 || written.size() < 3) begin
                a = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 63) : $urandom_range(0, 4095);
                send(OP_WRITE, a, $urandom_range(0, 4095), $urandom_range(0, 4095),
                     rand_coord(), rand_coord(), rand_coord());
            end else if (r < 76) begin
                a = pick_written();
                b = pick_written();
                c = pick_written();
                if ($urandom_range(0, 9) == 0) c = a;
                send(OP_FACE, a, b, c, 20'($urandom), 20'($urandom), 20'($urandom));
            end else if (r < 99) begin
                a = ($urandom_range(0, 9) < 7) ? pick_written() : $urandom_range(0, 4095);
                send(OP_READ, a, $urandom_range(0, 4095), $urandom_range(0, 4095),
                     20'($urandom), 20'($urandom), 20'($urandom));
            end else begin
                send(OP_CLEAR, $urandom_range(0, 4095), 0, 0, 0, 0, 0);
            end
        end

        wait_drained();
        repeat (200) @(posedge i_clk);
        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
